### src/lmc_pkg.sv
// Shared types and codes for the LED mode controller.
`default_nettype none

package lmc_pkg;

   localparam int NUM_CHAN = 3;
   localparam int TIMES_W = 48;
   localparam int MS_W = 16;
   localparam int CNT_W = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int TICK_PERIOD_MS_DEFAULT = 10;

   // item kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   // channel mode codes (codes 5..7 are stored but do nothing)
   localparam logic [2:0] MODE_OFF    = 3'd0;
   localparam logic [2:0] MODE_ON     = 3'd1;
   localparam logic [2:0] MODE_TOGGLE = 3'd2;
   localparam logic [2:0] MODE_BLINK  = 3'd3;
   localparam logic [2:0] MODE_PULSE  = 3'd4;

   // pulse phases (phase 3 is never entered)
   localparam logic [1:0] PHASE_GO_HIGH = 2'd0;
   localparam logic [1:0] PHASE_HOLD    = 2'd1;
   localparam logic [1:0] PHASE_GO_LOW  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_CHAN0_TIMES = 2'd0;
   localparam logic [1:0] REG_CHAN1_TIMES = 2'd1;
   localparam logic [1:0] REG_CHAN2_TIMES = 2'd2;

   // per-channel hold lengths in ticks
   typedef struct packed {
      logic [CNT_W-1:0] blink_on;
      logic [CNT_W-1:0] blink_off;
      logic [CNT_W-1:0] pulse;
   } lmc_limits_type;

   // per-channel controls from the top level
   typedef struct packed {
      logic       tick;
      logic       set;
      logic [2:0] new_mode;
   } lmc_ctrl_type;

endpackage

`default_nettype wire

### src/lmc_channel.sv
// One LED channel: mode register, blink and pulse sequencing.
`default_nettype none

module lmc_channel
   import lmc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire lmc_ctrl_type   ctrl,
   input  wire lmc_limits_type limits,
   output logic                drive_in
);

   logic [2:0]       mode_ff, mode_in;
   logic             steady_ff, steady_in;
   logic             bstarted_ff, bstarted_in;
   logic             blevel_ff, blevel_in;
   logic [CNT_W-1:0] bcount_ff, bcount_in;
   logic [1:0]       phase_ff, phase_in;
   logic             plevel_ff, plevel_in;
   logic [CNT_W-1:0] pcount_ff, pcount_in;
   logic [CNT_W-1:0] bcount_inc, pcount_inc, blink_lim;

   assign bcount_inc = bcount_ff + 1'b1;
   assign pcount_inc = pcount_ff + 1'b1;
   assign blink_lim  = blevel_ff ? limits.blink_on : limits.blink_off;

   always_comb begin
      mode_in     = mode_ff;
      steady_in   = steady_ff;
      bstarted_in = bstarted_ff;
      blevel_in   = blevel_ff;
      bcount_in   = bcount_ff;
      phase_in    = phase_ff;
      plevel_in   = plevel_ff;
      pcount_in   = pcount_ff;
      drive_in    = 1'b0;
      if (ctrl.set) begin
         mode_in = ctrl.new_mode;
      end else if (ctrl.tick) begin
         case (mode_ff)
            MODE_OFF: begin
               steady_in = 1'b0;
            end
            MODE_ON: begin
               steady_in = 1'b1;
               drive_in  = 1'b1;
            end
            MODE_TOGGLE: begin
               mode_in = steady_ff ? MODE_OFF : MODE_ON;
            end
            MODE_BLINK: begin
               if (!bstarted_ff) begin
                  blevel_in   = 1'b0;
                  bstarted_in = 1'b1;
               end else if (bcount_inc >= blink_lim) begin
                  bcount_in = '0;
                  blevel_in = ~blevel_ff;
               end else begin
                  bcount_in = bcount_inc;
               end
               drive_in = blevel_in;
            end
            MODE_PULSE: begin
               case (phase_ff)
                  PHASE_GO_HIGH: begin
                     plevel_in = 1'b1;
                     phase_in  = PHASE_HOLD;
                  end
                  PHASE_HOLD: begin
                     if (pcount_inc >= limits.pulse) begin
                        pcount_in = '0;
                        phase_in  = PHASE_GO_LOW;
                     end else begin
                        pcount_in = pcount_inc;
                     end
                  end
                  PHASE_GO_LOW: begin
                     plevel_in = 1'b0;
                     phase_in  = PHASE_GO_HIGH;
                     mode_in   = MODE_OFF;
                  end
                  default: begin
                  end
               endcase
               drive_in = plevel_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_OFF;
         steady_ff   <= 1'b0;
         bstarted_ff <= 1'b0;
         blevel_ff   <= 1'b0;
         bcount_ff   <= '0;
         phase_ff    <= PHASE_GO_HIGH;
         plevel_ff   <= 1'b0;
         pcount_ff   <= '0;
      end else begin
         mode_ff     <= mode_in;
         steady_ff   <= steady_in;
         bstarted_ff <= bstarted_in;
         blevel_ff   <= blevel_in;
         bcount_ff   <= bcount_in;
         phase_ff    <= phase_in;
         plevel_ff   <= plevel_in;
         pcount_ff   <= pcount_in;
      end
   end

endmodule

`default_nettype wire

### src/led_mode_controller_unit.sv
// Top level of the three-channel LED mode controller.
//
// Three-channel LED driver. A word with kind = set writes the mode of one
// channel (off, on, toggle, blink, pulse; a channel number of 3 is ignored)
// and returns nothing. A word with kind = tick steps all three channels and
// returns one word with the three pin levels. The channel state, and on a
// tick the result register, update at the edge that accepts the word, so
// a word can be taken every cycle when none is held off. The result register
// holds one finished word; a tick is held off only while that word is still
// stalled, set words pass regardless. Timing registers are 48 bits at byte
// addresses 0, 8 and 16 (blink on ms, blink off ms, pulse ms, 16 bits each).
// On a write the millisecond fields are turned into tick counts,
// floor(ms / TICK_PERIOD_MS), with a reciprocal multiply, so the counts are
// ready for the word right after the write. Reads return the raw value.
`default_nettype none

module led_mode_controller_unit
   import lmc_pkg::*;
#(
   parameter int TICK_PERIOD_MS = TICK_PERIOD_MS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [1:0]            req_chan,
   input  wire logic [2:0]            req_new_mode,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_drive0,
   output logic                       rsp_drive1,
   output logic                       rsp_drive2,
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // exact x / D for 16-bit x: (x * ceil(2^(16+L) / D)) >> (16+L), L = clog2(D)
   localparam int DIV_L = $clog2(TICK_PERIOD_MS);
   localparam int DIV_SHIFT = MS_W + DIV_L;
   localparam int RECIP_W = MS_W + 1;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TICK_PERIOD_MS) - 64'd1) /
               64'(TICK_PERIOD_MS));

   function automatic logic [CNT_W-1:0] ticks_of(input logic [MS_W-1:0] ms);
      logic [MS_W+RECIP_W-1:0] prod;
      prod = {{RECIP_W{1'b0}}, ms} * {{MS_W{1'b0}}, DIV_RECIP};
      return CNT_W'(prod >> DIV_SHIFT);
   endfunction

   logic [TIMES_W-1:0] times_ff [NUM_CHAN];
   lmc_limits_type     limits_ff [NUM_CHAN];
   logic               csr_wr;
   logic [1:0]         csr_idx;
   lmc_limits_type     wr_limits;

   logic               req_accept;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NUM_CHAN-1:0] drive_ff, drive_in;
   lmc_ctrl_type       ctrl [NUM_CHAN];

   // register port: no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:3];

   assign wr_limits.blink_on  = ticks_of(csr_pwdata[15:0]);
   assign wr_limits.blink_off = ticks_of(csr_pwdata[31:16]);
   assign wr_limits.pulse     = ticks_of(csr_pwdata[47:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            times_ff[i]  <= '0;
            limits_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            if (csr_idx == 2'(i)) begin
               times_ff[i]  <= csr_pwdata[TIMES_W-1:0];
               limits_ff[i] <= wr_limits;
            end
         end
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CHAN0_TIMES: csr_prdata = CSR_DATA_W'(times_ff[0]);
         REG_CHAN1_TIMES: csr_prdata = CSR_DATA_W'(times_ff[1]);
         REG_CHAN2_TIMES: csr_prdata = CSR_DATA_W'(times_ff[2]);
         default:         csr_prdata = '0;
      endcase
   end

   // a tick needs the result slot; a set word never does
   assign req_stall  = rsp_valid_ff & rsp_stall & (req_kind == KIND_TICK);
   assign req_accept = req_valid & ~req_stall;

   generate
      for (genvar g = 0; g < NUM_CHAN; g++) begin : g_chan
         assign ctrl[g].tick     = req_accept & (req_kind == KIND_TICK);
         assign ctrl[g].set      = req_accept & (req_kind == KIND_SET) &
                                   (req_chan == 2'(g));
         assign ctrl[g].new_mode = req_new_mode;

         lmc_channel u_chan (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl[g]),
            .limits   (limits_ff[g]),
            .drive_in (drive_in[g])
         );
      end
   endgenerate

   // result register: loads on a tick, clears when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_accept && req_kind == KIND_TICK) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_kind == KIND_TICK) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_drive0 = drive_ff[0];
   assign rsp_drive1 = drive_ff[1];
   assign rsp_drive2 = drive_ff[2];

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for the three-channel LED mode controller.
`timescale 1ns / 100ps

import lmc_pkg::*;

// Tracks channel state, predicts pin levels per tick and checks returned words.
class led_drive_scoreboard;
   localparam int TICK_MS = TICK_PERIOD_MS_DEFAULT;

   logic [TIMES_W-1:0] times [NUM_CHAN];
   logic [2:0]         mode [NUM_CHAN];
   logic               steady [NUM_CHAN];
   logic               blink_began [NUM_CHAN];
   logic               blink_lvl [NUM_CHAN];
   logic [CNT_W-1:0]   blink_cnt [NUM_CHAN];
   logic [1:0]         pulse_ph [NUM_CHAN];
   logic               pulse_lvl [NUM_CHAN];
   logic [CNT_W-1:0]   pulse_cnt [NUM_CHAN];

   // expected pin levels, bit c = channel c
   logic [NUM_CHAN-1:0] drive_due [$];
   int errors;
   int ticks;
   int sets;

   function new();
      for (int c = 0; c < NUM_CHAN; c++) begin
         times[c] = '0;
         mode[c] = MODE_OFF;
         steady[c] = 1'b0;
         blink_began[c] = 1'b0;
         blink_lvl[c] = 1'b0;
         blink_cnt[c] = '0;
         pulse_ph[c] = PHASE_GO_HIGH;
         pulse_lvl[c] = 1'b0;
         pulse_cnt[c] = '0;
      end
      errors = 0;
      ticks = 0;
      sets = 0;
   endfunction

   function void set_times(int idx, logic [TIMES_W-1:0] value);
      times[idx] = value;
   endfunction

   function int unsigned hold_ticks(logic [MS_W-1:0] ms);
      return int'(ms) / TICK_MS;
   endfunction

   function int pending();
      return drive_due.size();
   endfunction

   // one channel's step on a tick; returns its pin level
   function logic step_channel(int c);
      logic lvl;
      int unsigned lim;
      lvl = 1'b0;
      case (mode[c])
         MODE_OFF: steady[c] = 1'b0;
         MODE_ON: begin
            steady[c] = 1'b1;
            lvl = 1'b1;
         end
         MODE_TOGGLE: mode[c] = steady[c] ? MODE_OFF : MODE_ON;
         MODE_BLINK: begin
            if (!blink_began[c]) begin
               blink_lvl[c] = 1'b0;
               blink_began[c] = 1'b1;
            end else begin
               // high level holds for the on time, low for the off time
               lim = blink_lvl[c] ? hold_ticks(times[c][15:0]) : hold_ticks(times[c][31:16]);
               blink_cnt[c] = blink_cnt[c] + 16'd1;
               if ({16'd0, blink_cnt[c]} >= lim) begin
                  blink_cnt[c] = '0;
                  blink_lvl[c] = ~blink_lvl[c];
               end
            end
            lvl = blink_lvl[c];
         end
         MODE_PULSE: begin
            case (pulse_ph[c])
               PHASE_GO_HIGH: begin
                  pulse_lvl[c] = 1'b1;
                  pulse_ph[c] = PHASE_HOLD;
               end
               PHASE_HOLD: begin
                  pulse_cnt[c] = pulse_cnt[c] + 16'd1;
                  if ({16'd0, pulse_cnt[c]} >= hold_ticks(times[c][47:32])) begin
                     pulse_cnt[c] = '0;
                     pulse_ph[c] = PHASE_GO_LOW;
                  end
               end
               PHASE_GO_LOW: begin
                  pulse_lvl[c] = 1'b0;
                  pulse_ph[c] = PHASE_GO_HIGH;
                  mode[c] = MODE_OFF;
               end
               default: ;
            endcase
            lvl = pulse_lvl[c];
         end
         default: ;
      endcase
      return lvl;
   endfunction

   function void note_word(logic kind, logic [1:0] chan, logic [2:0] new_mode);
      logic [NUM_CHAN-1:0] lv;
      if (kind == KIND_SET) begin
         sets++;
         if (chan < NUM_CHAN) mode[chan] = new_mode;
      end else begin
         ticks++;
         for (int c = 0; c < NUM_CHAN; c++) lv[c] = step_channel(c);
         drive_due.push_back(lv);
      end
   endfunction

   function void check_drive(logic d0, logic d1, logic d2);
      logic [NUM_CHAN-1:0] want;
      if (drive_due.size() == 0) begin
         $error("result word with no tick outstanding: drive0=%0b drive1=%0b drive2=%0b",
                d0, d1, d2);
         errors++;
         return;
      end
      want = drive_due.pop_front();
      if (d0 !== want[0]) begin
         $error("drive0 mismatch: expected %0b, got %0b", want[0], d0);
         errors++;
      end
      if (d1 !== want[1]) begin
         $error("drive1 mismatch: expected %0b, got %0b", want[1], d1);
         errors++;
      end
      if (d2 !== want[2]) begin
         $error("drive2 mismatch: expected %0b, got %0b", want[2], d2);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam int TICK_MS = TICK_PERIOD_MS_DEFAULT;
   localparam int HOLD_CYCLES = 40;      // long receiver hold-off
   localparam int SETTLE_CYCLES = 4;     // margin for the pipeline to settle
   localparam logic [1:0] CHAN_NONE = 2'd3;           // no such channel
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;       // stored, does nothing
   localparam logic [2:0] MODE_SPARE_MID = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam logic [TIMES_W-1:0] TIMES_ALL_ONES = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_kind = KIND_TICK;
   logic [1:0] req_chan = '0;
   logic [2:0] req_new_mode = MODE_OFF;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_drive0;
   logic rsp_drive1;
   logic rsp_drive2;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   led_drive_scoreboard sb;
   int  csr_errors = 0;
   int  settings = 0;
   // handshakes between the sender thread and the receiver thread
   bit  long_hold_req = 1'b0;
   bit  quiet_tail = 1'b0;

   led_mode_controller_unit #(
      .TICK_PERIOD_MS(TICK_MS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_chan(req_chan),
      .req_new_mode(req_new_mode),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive0(rsp_drive0),
      .rsp_drive1(rsp_drive1),
      .rsp_drive2(rsp_drive2),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Monitor: everything sampled at the rising edge, before the DUT's
   // registers update. Results are checked ahead of noting the new word;
   // a result can never belong to a tick accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_drive(rsp_drive0, rsp_drive1, rsp_drive2);
         if (req_valid && !req_stall) sb.note_word(req_kind, req_chan, req_new_mode);
      end
   end

   // Receiver: random stall bursts mixed with clean runs,
   // a long hold-off on request, and no stalls at all in the tail.
   initial begin : rsp_side
      int hold_left;
      int burst_left;
      int run_left;
      hold_left = 0;
      burst_left = 0;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_tail) begin
            rsp_stall <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            burst_left = $urandom_range(1, 6) - 1;
            rsp_stall <= 1'b1;
         end else begin
            run_left = $urandom_range(0, 12);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one word and hold it until the edge that takes it.
   task automatic send_word(input logic kind, input logic [1:0] chan, input logic [2:0] nm);
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_chan <= chan;
      req_new_mode <= nm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stop offering and wait until every tick has been answered, then let
   // the pipeline settle so a late set word cannot race a register write.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(input int idx);
      return CSR_ADDR_W'(idx * 8);
   endfunction

   task automatic write_times(input int idx, input logic [TIMES_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= reg_addr(idx);
      csr_pwdata <= {{(CSR_DATA_W-TIMES_W){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_times(idx, value);
   endtask

   task automatic read_times(input int idx);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= reg_addr(idx);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[TIMES_W-1:0] !== sb.times[idx]) begin
         $error("chan%0d_times readback mismatch: expected %h, got %h",
                idx, sb.times[idx], csr_prdata[TIMES_W-1:0]);
         csr_errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Millisecond field: mostly a few ticks, sometimes zero, under one
   // tick, or all ones (the 16-bit maximum).
   function automatic logic [MS_W-1:0] rand_ms();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return MS_W'($urandom_range(1, TICK_MS - 1));
         default: return MS_W'($urandom_range(TICK_MS, 7 * TICK_MS));
      endcase
   endfunction

   task automatic load_all(input int style);
      logic [TIMES_W-1:0] v;
      for (int i = 0; i < NUM_CHAN; i++) begin
         case (style)
            0: v = {rand_ms(), rand_ms(), rand_ms()};
            1: v = TIMES_ALL_ONES;
            default: v = '0;
         endcase
         write_times(i, v);
         read_times(i);
      end
      settings++;
   endtask

   // Random traffic built as "set a mode, then a run of ticks", so blink
   // and pulse sequences play out; about one set in ten goes to the
   // missing channel and a few carry spare mode codes.
   task automatic run_phase(input int n, input bit gaps, input int hold_at, input int pause_at);
      int run_left;
      logic kind;
      logic [1:0] chan;
      logic [2:0] nm;
      run_left = 0;
      for (int i = 0; i < n; i++) begin
         if (run_left == 0) begin
            kind = KIND_SET;
            chan = ($urandom_range(0, 9) == 0) ? CHAN_NONE : 2'($urandom_range(0, 2));
            nm = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))
                                             : 3'($urandom_range(MODE_OFF, MODE_PULSE));
            run_left = $urandom_range(0, 10);
         end else begin
            // channel and mode are don't-care on a tick; randomize them anyway
            kind = KIND_TICK;
            chan = 2'($urandom_range(0, 3));
            nm = 3'($urandom_range(0, 7));
            run_left--;
         end
         send_word(kind, chan, nm);
         if (i == hold_at) long_hold_req = 1'b1;
         if (i == pause_at) drain();
         if (gaps && $urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 6));
      end
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers come out of reset as zero
      for (int i = 0; i < NUM_CHAN; i++) read_times(i);

      // Directed: channel 0 with short holds (on 1, off 2, pulse 3 ticks),
      // channel 1 with zero holds, channel 2 with every bit set.
      write_times(REG_CHAN0_TIMES, {16'd30, 16'd20, 16'd10});
      write_times(REG_CHAN1_TIMES, '0);
      write_times(REG_CHAN2_TIMES, TIMES_ALL_ONES);
      settings++;

      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_SET, 2'd0, MODE_ON);
      send_word(KIND_SET, 2'd1, MODE_TOGGLE);      // steady low -> becomes on
      send_word(KIND_SET, 2'd2, MODE_BLINK);       // first blink tick is low
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_TICK, CHAN_NONE, MODE_SPARE_HI);
      send_word(KIND_SET, 2'd0, MODE_TOGGLE);      // steady high -> becomes off
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_SET, 2'd1, MODE_PULSE);       // zero hold: ends at first count
      send_word(KIND_SET, 2'd0, MODE_BLINK);
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_SET, CHAN_NONE, MODE_ON);     // missing channel: ignored
      send_word(KIND_SET, 2'd2, MODE_SPARE_HI);    // spare code drives low
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_SET, 2'd0, MODE_SPARE_LO);
      send_word(KIND_SET, 2'd2, MODE_PULSE);       // long hold on channel 2
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      send_word(KIND_SET, 2'd0, MODE_BLINK);       // blink resumes with kept state
      send_word(KIND_SET, 2'd1, MODE_SPARE_MID);
      send_word(KIND_TICK, 2'd0, MODE_OFF);
      drain();

      // random settings, long receiver hold-off partway in
      load_all(0);
      run_phase(130, 1'b1, 40, -1);
      drain();

      // every hold at its maximum; sender pauses for a full drain midway
      load_all(1);
      run_phase(130, 1'b1, -1, 65);
      drain();

      // every hold zero: blink flips on each counted tick
      load_all(2);
      run_phase(130, 1'b1, 20, -1);
      drain();

      // tail: fresh random settings, no idling on either side
      load_all(0);
      @(posedge clock);
      quiet_tail = 1'b1;
      run_phase(130, 1'b0, -1, -1);
      drain();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d words: %0d ticks checked, %0d mode sets (spare codes and",
               sb.ticks + sb.sets, sb.ticks, sb.sets);
      $display("missing channel included) across %0d timing settings.", settings);
      if (sb.errors + csr_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
